// File: rtl/json_string_unescape_utf8_defines.svh
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_defines.svh
// Assertion macros shared by the string unescaper modules. Each macro expects
// clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, off while in reset
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Run queue geometry
  localparam int unsigned JsuQDepth = 4;
  localparam int unsigned JsuQAw    = $clog2(JsuQDepth);
  localparam int unsigned JsuQCw    = JsuQAw + 1;

  // Characters with a meaning in the escape grammar
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;

  // UTF-16 surrogate ranges and UTF-8 limits
  localparam logic [15:0] HighSurLo = 16'hD800;
  localparam logic [15:0] HighSurHi = 16'hDBFF;
  localparam logic [15:0] LowSurLo  = 16'hDC00;
  localparam logic [15:0] LowSurHi  = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Utf8Lim1  = 21'h80;
  localparam logic [20:0] Utf8Lim2  = 21'h800;
  localparam logic [20:0] Utf8Lim3  = 21'h10000;

  // Lead and continuation byte prefixes
  localparam logic [1:0] ContPfx  = 2'b10;
  localparam logic [2:0] Lead2Pfx = 3'b110;
  localparam logic [3:0] Lead3Pfx = 4'b1110;
  localparam logic [4:0] Lead4Pfx = 5'b11110;

  // One run of output bytes caused by one input beat
  typedef struct packed {
    logic [3:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      cnt_m1;  // number of bytes minus one
    logic            bare;    // end marker with no data byte
    logic            last;    // run closes the string
    logic            trunc;   // string ended inside an escape
  } jsu_run_t;

  // Queue status toward the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } jsu_q_stat_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
  } utf8_seq_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  // ASCII hex digit to nibble; ok low on anything else
  function automatic hex_dig_t hex_decode(input logic [7:0] c);
    hex_dig_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // Code point to 1..4 byte UTF-8
  function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
    utf8_seq_t s;
    s.bytes = '0;
    if (cp < Utf8Lim1) begin
      s.bytes[0] = cp[7:0];
      s.cnt_m1   = 2'd0;
    end else if (cp < Utf8Lim2) begin
      s.bytes[0] = {Lead2Pfx, cp[10:6]};
      s.bytes[1] = {ContPfx, cp[5:0]};
      s.cnt_m1   = 2'd1;
    end else if (cp < Utf8Lim3) begin
      s.bytes[0] = {Lead3Pfx, cp[15:12]};
      s.bytes[1] = {ContPfx, cp[11:6]};
      s.bytes[2] = {ContPfx, cp[5:0]};
      s.cnt_m1   = 2'd2;
    end else begin
      s.bytes[0] = {Lead4Pfx, cp[20:18]};
      s.bytes[1] = {ContPfx, cp[17:12]};
      s.bytes[2] = {ContPfx, cp[11:6]};
      s.bytes[3] = {ContPfx, cp[5:0]};
      s.cnt_m1   = 2'd3;
    end
    return s;
  endfunction

endpackage

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one string byte per beat, tracks the escape phase and
// pushes the run of output bytes that the beat causes into the run queue.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  input  jsu_pkg::jsu_q_stat_t q_stat_i,
  output logic               push_o,
  output jsu_pkg::jsu_run_t  run_o
);

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_ESC,
    PH_HEX1,
    PH_WAIT_BS,
    PH_WAIT_U,
    PH_HEX2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic               acc_beat;
  jsu_pkg::hex_dig_t  hdig;
  logic [15:0]        sh_acc;
  logic               sh_bad;
  logic [15:0]        hval;
  logic [20:0]        pair_cp;
  jsu_pkg::utf8_seq_t enc_bmp;
  jsu_pkg::utf8_seq_t enc_pair;
  logic [7:0]         esc_byte;
  logic               has_data;
  logic [3:0][7:0]    out_bytes;
  logic [1:0]         out_cnt_m1;
  logic               trunc;
  logic               is_low;
  logic               is_high;

  assign in_ready_o = !q_stat_i.full;
  assign acc_beat   = in_valid_i && in_ready_o;

  // Hex digit datapath
  assign hdig    = jsu_pkg::hex_decode(in_byte_i);
  assign sh_acc  = {acc_q[11:0], hdig.val};
  assign sh_bad  = bad_q || !hdig.ok;
  assign hval    = sh_bad ? 16'd0 : sh_acc;
  assign is_low  = (hval >= jsu_pkg::LowSurLo) && (hval <= jsu_pkg::LowSurHi);
  assign is_high = (hval >= jsu_pkg::HighSurLo) && (hval <= jsu_pkg::HighSurHi);
  assign pair_cp = jsu_pkg::SuppBase + {1'b0, hs_q, hval[9:0]};
  assign enc_bmp  = jsu_pkg::utf8_encode({5'd0, hval});
  assign enc_pair = jsu_pkg::utf8_encode(pair_cp);

  // Character named by a single-letter escape
  always_comb begin
    unique case (in_byte_i)
      jsu_pkg::ChLowerB: esc_byte = jsu_pkg::ChBackspace;
      jsu_pkg::ChLowerF: esc_byte = jsu_pkg::ChFormFeed;
      jsu_pkg::ChLowerN: esc_byte = jsu_pkg::ChNewline;
      jsu_pkg::ChLowerR: esc_byte = jsu_pkg::ChReturn;
      jsu_pkg::ChLowerT: esc_byte = jsu_pkg::ChTab;
      default:           esc_byte = in_byte_i;
    endcase
  end

  // Next phase and the run for this beat
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    bad_d      = bad_q;
    cnt_d      = cnt_q;
    hs_d       = hs_q;
    has_data   = 1'b0;
    out_bytes  = '0;
    out_cnt_m1 = 2'd0;
    unique case (phase_q)
      PH_ESC, PH_WAIT_U: begin
        if (in_byte_i == jsu_pkg::ChLowerU) begin
          phase_d = (phase_q == PH_ESC) ? PH_HEX1 : PH_HEX2;
          acc_d   = 16'd0;
          bad_d   = 1'b0;
          cnt_d   = 2'd0;
        end else begin
          phase_d      = PH_PLAIN;
          has_data     = 1'b1;
          out_bytes[0] = esc_byte;
        end
      end
      PH_WAIT_BS: begin
        if (in_byte_i == jsu_pkg::ChBackslash) begin
          phase_d = PH_WAIT_U;
        end else begin
          phase_d      = PH_PLAIN;
          has_data     = 1'b1;
          out_bytes[0] = in_byte_i;
        end
      end
      PH_HEX1, PH_HEX2: begin
        acc_d = sh_acc;
        bad_d = sh_bad;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d   = 2'd0;
          phase_d = PH_PLAIN;
          if (phase_q == PH_HEX1) begin
            if (hval == 16'd0 || is_low) begin
              has_data = 1'b0;
            end else if (is_high) begin
              hs_d    = hval[9:0];
              phase_d = PH_WAIT_BS;
            end else begin
              has_data   = 1'b1;
              out_bytes  = enc_bmp.bytes;
              out_cnt_m1 = enc_bmp.cnt_m1;
            end
          end else if (is_low) begin
            has_data   = 1'b1;
            out_bytes  = enc_pair.bytes;
            out_cnt_m1 = enc_pair.cnt_m1;
          end
        end
      end
      default: begin
        // plain text
        if (in_byte_i == jsu_pkg::ChBackslash) begin
          phase_d = PH_ESC;
        end else begin
          phase_d      = PH_PLAIN;
          has_data     = 1'b1;
          out_bytes[0] = in_byte_i;
        end
      end
    endcase

    // End of string inside an escape is flagged; all state returns to reset
    trunc = (phase_d == PH_ESC) || (phase_d == PH_HEX1) ||
            (phase_d == PH_WAIT_U) || (phase_d == PH_HEX2);
    if (in_last_i) begin
      phase_d = PH_PLAIN;
      acc_d   = 16'd0;
      bad_d   = 1'b0;
      cnt_d   = 2'd0;
      hs_d    = 10'd0;
    end
  end

  // Run descriptor toward the queue
  assign push_o       = acc_beat && (has_data || in_last_i);
  assign run_o.bytes  = out_bytes;
  assign run_o.cnt_m1 = out_cnt_m1;
  assign run_o.bare   = !has_data;
  assign run_o.last   = in_last_i;
  assign run_o.trunc  = in_last_i && trunc;

  // Escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= 16'd0;
      bad_q   <= 1'b0;
      cnt_q   <= 2'd0;
      hs_q    <= 10'd0;
    end else if (acc_beat) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

  `JSU_ASSERT_NXT(a_last_clears, acc_beat && in_last_i, phase_q == PH_PLAIN && cnt_q == 2'd0 && !bad_q, "escape state not cleared after string end")

endmodule

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of run descriptors between the escape decoder and the byte
// serializer; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jsu_pkg::jsu_run_t    push_run_i,
  input  logic                 pop_i,
  output jsu_pkg::jsu_run_t    head_o,
  output jsu_pkg::jsu_q_stat_t stat_o
);

  jsu_pkg::jsu_run_t mem_q [jsu_pkg::JsuQDepth];

  logic [jsu_pkg::JsuQAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::JsuQCw-1:0] count_q;

  localparam logic [jsu_pkg::JsuQAw-1:0] PtrMax = jsu_pkg::JsuQAw'(jsu_pkg::JsuQDepth - 1);
  localparam logic [jsu_pkg::JsuQCw-1:0] CntFull = jsu_pkg::JsuQCw'(jsu_pkg::JsuQDepth);

  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `JSU_ASSERT_IMP(a_no_overflow, push_i, !stat_o.full, "push into full run queue")
  `JSU_ASSERT_IMP(a_no_underflow, pop_i, !stat_o.empty, "pop from empty run queue")

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Byte serializer: walks the head run of the queue one byte per beat into a
// registered output stage.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsu_pkg::jsu_run_t    head_i,
  input  jsu_pkg::jsu_q_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_data_o,
  output logic [2:0]           out_user_o,  // byte_valid, run_last, truncated
  output logic                 out_last_o   // string_end
);

  logic [1:0] idx_q;
  logic       vld_q;
  logic [7:0] data_q;
  logic [2:0] user_q;
  logic       last_q;
  logic       slot_free;
  logic       load;
  logic       run_fin;

  assign slot_free = !vld_q || out_ready_i;
  assign load      = slot_free && !q_stat_i.empty;
  assign run_fin   = (idx_q == head_i.cnt_m1);
  assign pop_o     = load && run_fin;

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= head_i.bytes[idx_q];
      user_q <= {run_fin && head_i.last && head_i.trunc, run_fin, !head_i.bare};
      last_q <= run_fin && head_i.last;
    end
  end

  // Output valid and byte index within the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (slot_free) begin
        vld_q <= !q_stat_i.empty;
      end
      if (load) begin
        idx_q <= run_fin ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

  `JSU_ASSERT_IMP(a_end_closes_run, vld_q && last_q, user_q[1], "string end on a beat that does not close its run")
  `JSU_ASSERT_IMP(a_trunc_at_end, vld_q && user_q[2], last_q, "truncated flag away from string end")

endmodule

// File: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with \uXXXX to UTF-8 transcoding. One body byte
// enters per beat; each beat yields zero to four output bytes, and the final
// byte of a string always yields at least one beat (a bare end marker when it
// has no data). Input is taken at one byte per cycle as long as the four-entry
// run queue has room; output leaves at one byte per cycle while the receiver
// is ready and the queue is not empty, so an escape that expands to N bytes
// occupies N output beats. Each beat is decoded straight into a queue entry,
// then the serializer's output stage loads it. The escape decoder, run queue
// and byte serializer each stall independently.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // in_byte
  input  logic       s_axis_tlast_i,   // string_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic [2:0] m_axis_tuser_o,   // [0] byte_valid, [1] run_last, [2] truncated
  output logic       m_axis_tlast_o    // string_end
);

  logic                 push;
  jsu_pkg::jsu_run_t    push_run;
  logic                 pop;
  jsu_pkg::jsu_run_t    head;
  jsu_pkg::jsu_q_stat_t q_stat;

  // Escape decoder
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .run_o      (push_run)
  );

  // Run queue
  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Byte serializer
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: bench/jsu_unescape_checker.sv
// ----------------------------------------------------------------------------
// jsu_unescape_checker
// Watches both stream channels of the JSON string unescaper, decodes every
// accepted input beat on its own copy of the escape state, and compares each
// accepted output beat with the oldest predicted beat.
// ----------------------------------------------------------------------------
module jsu_unescape_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,   // in_byte
  input  logic       s_axis_tlast_i,   // string_last
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,   // out_byte
  input  logic [2:0] m_axis_tuser_i,   // [0] byte_valid, [1] run_last, [2] truncated
  input  logic       m_axis_tlast_i,   // string_end
  output int         pending_o,
  output int         fail_count_o
);

  typedef enum logic [2:0] {
    PhPlain,
    PhEsc,
    PhHex1,
    PhWaitBs,
    PhWaitU,
    PhHex2
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       str_end;
    logic       trunc;
  } out_beat_t;

  // Decoder state
  esc_phase_e  phase;
  logic [15:0] hex_acc;
  logic        hex_bad;
  logic [1:0]  digit_cnt;
  logic [9:0]  high_bits;

  out_beat_t   expected_bytes[$];
  out_beat_t   got;
  out_beat_t   want;
  int          fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  // {ok, value} of an ASCII hex digit; zero on anything else
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else begin
      return 5'b0;
    end
    return {1'b1, d[3:0]};
  endfunction

  // UTF-8 bytes of a code point, first byte in seq[0]; returns byte count
  function automatic int utf8_of(input logic [20:0] cp, output logic [3:0][7:0] seq);
    seq = '0;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      seq[0] = 8'hC0 | 8'(cp >> 6);
      seq[1] = 8'h80 | 8'(cp & 21'h3F);
      return 2;
    end
    if (cp < 21'h10000) begin
      seq[0] = 8'hE0 | 8'(cp >> 12);
      seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
      seq[2] = 8'h80 | 8'(cp & 21'h3F);
      return 3;
    end
    seq[0] = 8'hF0 | 8'((cp >> 18) & 21'h7);
    seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
    seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
    seq[3] = 8'h80 | 8'(cp & 21'h3F);
    return 4;
  endfunction

  task automatic clear_state();
    phase     = PhPlain;
    hex_acc   = '0;
    hex_bad   = 1'b0;
    digit_cnt = '0;
    high_bits = '0;
  endtask

  task automatic start_hex(input esc_phase_e ph);
    phase     = ph;
    hex_acc   = '0;
    hex_bad   = 1'b0;
    digit_cnt = '0;
  endtask

  // Character after a backslash
  task automatic take_escaped(input logic [7:0] c, output logic [3:0][7:0] seq,
                              output int n);
    seq   = '0;
    n     = 1;
    phase = PhPlain;
    case (c)
      jsu_pkg::ChLowerB: seq[0] = jsu_pkg::ChBackspace;
      jsu_pkg::ChLowerF: seq[0] = jsu_pkg::ChFormFeed;
      jsu_pkg::ChLowerN: seq[0] = jsu_pkg::ChNewline;
      jsu_pkg::ChLowerR: seq[0] = jsu_pkg::ChReturn;
      jsu_pkg::ChLowerT: seq[0] = jsu_pkg::ChTab;
      jsu_pkg::ChLowerU: begin
        start_hex(PhHex1);
        n = 0;
      end
      default:  seq[0] = c;
    endcase
  endtask

  // One of four hex digits, of either the first or the second escape
  task automatic take_hex_digit(input logic [7:0] c, output logic [3:0][7:0] seq,
                                output int n);
    logic [4:0]  nib;
    logic [15:0] v;
    seq = '0;
    n   = 0;
    nib = nibble_of(c);
    if (!nib[4]) hex_bad = 1'b1;
    hex_acc = {hex_acc[11:0], nib[3:0]};
    if (digit_cnt < 2'd3) begin
      digit_cnt++;
      return;
    end
    v         = hex_bad ? 16'h0000 : hex_acc;
    digit_cnt = '0;
    if (phase == PhHex1) begin
      phase = PhPlain;
      // zero and a lone low surrogate vanish
      if (v == 16'h0000 || (v >= jsu_pkg::LowSurLo && v <= jsu_pkg::LowSurHi)) return;
      if (v >= jsu_pkg::HighSurLo && v <= jsu_pkg::HighSurHi) begin
        high_bits = v[9:0];
        phase     = PhWaitBs;
        return;
      end
      n = utf8_of({5'd0, v}, seq);
    end else begin
      phase = PhPlain;
      // second half must be a low surrogate, else the pair is dropped
      if (v < jsu_pkg::LowSurLo || v > jsu_pkg::LowSurHi) return;
      n = utf8_of(jsu_pkg::SuppBase + {1'b0, high_bits, v[9:0]}, seq);
    end
  endtask

  // Predict the output beats of one accepted body byte
  task automatic decode_body_byte(input logic [7:0] c, input logic last);
    logic [3:0][7:0] seq;
    int              n;
    logic            trunc;
    out_beat_t       r;
    seq = '0;
    n   = 0;
    case (phase)
      PhEsc: take_escaped(c, seq, n);
      PhWaitU: begin
        if (c == jsu_pkg::ChLowerU) start_hex(PhHex2);
        else take_escaped(c, seq, n);
      end
      PhWaitBs: begin
        if (c == jsu_pkg::ChBackslash) begin
          phase = PhWaitU;
        end else begin
          phase  = PhPlain;
          seq[0] = c;
          n      = 1;
        end
      end
      PhHex1, PhHex2: take_hex_digit(c, seq, n);
      default: begin
        phase = PhPlain;
        if (c == jsu_pkg::ChBackslash) begin
          phase = PhEsc;
        end else begin
          seq[0] = c;
          n      = 1;
        end
      end
    endcase

    trunc = 1'b0;
    if (last) begin
      trunc = phase inside {PhEsc, PhHex1, PhWaitU, PhHex2};
      clear_state();
      if (n == 0) begin
        // bare end marker
        r.data     = 8'h00;
        r.valid    = 1'b0;
        r.run_last = 1'b1;
        r.str_end  = 1'b1;
        r.trunc    = trunc;
        expected_bytes = {expected_bytes, r};
        return;
      end
    end

    for (int k = 0; k < n; k++) begin
      r.data     = seq[k];
      r.valid    = 1'b1;
      r.run_last = (k == n - 1);
      r.str_end  = r.run_last && last;
      r.trunc    = r.str_end && trunc;
      expected_bytes = {expected_bytes, r};
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        decode_body_byte(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.data     = m_axis_tdata_i;
        got.valid    = m_axis_tuser_i[0];
        got.run_last = m_axis_tuser_i[1];
        got.str_end  = m_axis_tlast_i;
        got.trunc    = m_axis_tuser_i[2];
        if (expected_bytes.size() == 0) begin
          $display("%0t: output beat with nothing expected: data %02h valid %0b run_last %0b end %0b trunc %0b",
                   $time, got.data, got.valid, got.run_last, got.str_end, got.trunc);
          fail_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            $display("%0t: output beat mismatch: expected data %02h valid %0b run_last %0b end %0b trunc %0b",
                     $time, want.data, want.valid, want.run_last, want.str_end, want.trunc);
            $display("%0t:                       actual   data %02h valid %0b run_last %0b end %0b trunc %0b",
                     $time, got.data, got.valid, got.run_last, got.str_end, got.trunc);
            fail_cnt++;
          end
        end
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// File: bench/tb_json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Feeds JSON string bodies into the unescaper: a few directed strings, then
// random strings built from plain bytes, simple escapes, \uXXXX escapes and
// surrogate pairs (valid, broken, bad hex, cut short). Both sides idle in
// random bursts; the receiver holds off once for a long stretch and the
// sender pauses once until the output drains. The checker does the checking.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;

  localparam int ResetCycles  = 8;
  localparam int RandomBeats  = 320;
  localparam int QuietAfter   = 270;
  localparam int HoldAfter    = 120;
  localparam int RxHoldCycles = 60;
  localparam int DrainCycles  = 20;
  localparam int IdleLimit    = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int         pending;
  int         fail_count;

  logic       quiet;
  logic       rx_hold_req;
  logic [7:0] str_bytes[$];
  int         beats_sent    = 0;
  int         strings_sent  = 0;
  int         hex_escapes   = 0;
  int         pair_attempts = 0;
  int         cut_strings   = 0;
  int         idle_cycles   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  json_string_unescape_utf8 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  jsu_unescape_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Append one byte to the string under construction
  function automatic void put_byte(input logic [7:0] b);
    str_bytes = {str_bytes, b};
  endfunction

  // Offer one body byte, with an optional idle burst ahead of it
  task automatic send_beat(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_string();
    int sz;
    sz = str_bytes.size();
    for (int i = 0; i < sz; i++) send_beat(str_bytes[i], i == sz - 1);
    str_bytes.delete();
    strings_sent++;
  endtask

  // Lower the valid and wait until every predicted beat has come out
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // \uXXXX in mixed case; may corrupt one digit when allowed
  task automatic add_hex(input logic [15:0] v, input logic allow_bad);
    int bad_pos;
    bad_pos = -1;
    if (allow_bad && $urandom_range(0, 9) == 0) bad_pos = $urandom_range(0, 3);
    put_byte(jsu_pkg::ChBackslash);
    put_byte(jsu_pkg::ChLowerU);
    for (int i = 3; i >= 0; i--) begin
      if (i == bad_pos) begin
        // g..z or G..Z, never a hex digit
        put_byte(($urandom_range(0, 1) ? 8'h67 : 8'h47) + 8'($urandom_range(0, 19)));
      end else begin
        put_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
      end
    end
    hex_escapes++;
  endtask

  task automatic add_code_point();
    logic [15:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'($urandom_range(16'h0001, 16'h007F));
      1: v = 16'($urandom_range(16'h0080, 16'h07FF));
      2: v = 16'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                      : $urandom_range(16'hE000, 16'hFFFF));
      3: v = 16'h0000;
      4: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: v = 16'($urandom_range(0, 16'hFFFF));
    endcase
    add_hex(v, 1'b1);
  endtask

  // High surrogate and one of the ways it can be followed
  task automatic add_surrogate_pair();
    logic [7:0] b;
    add_hex(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1);
    pair_attempts++;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: add_hex(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b1);
      4: add_hex(16'($urandom_range(16'h0000, 16'hDBFF)), 1'b1);
      5: put_byte(8'($urandom_range(0, 255)));
      6: begin
        b = 8'($urandom_range(0, 255));
        if (b == jsu_pkg::ChLowerU) b = jsu_pkg::ChLowerN;
        put_byte(jsu_pkg::ChBackslash);
        put_byte(b);
      end
      default: ;
    endcase
  endtask

  task automatic add_token();
    case ($urandom_range(0, 9))
      0, 1, 2: put_byte(8'($urandom_range(0, 255)));
      3, 4: begin
        put_byte(jsu_pkg::ChBackslash);
        case ($urandom_range(0, 6))
          0: put_byte(jsu_pkg::ChLowerB);
          1: put_byte(jsu_pkg::ChLowerF);
          2: put_byte(jsu_pkg::ChLowerN);
          3: put_byte(jsu_pkg::ChLowerR);
          4: put_byte(jsu_pkg::ChLowerT);
          5: put_byte(jsu_pkg::ChBackslash);
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
      5, 6, 7: add_code_point();
      default: add_surrogate_pair();
    endcase
  endtask

  // Random string; some are cut at an arbitrary byte and may end mid-escape
  task automatic build_random_string();
    int cut;
    repeat ($urandom_range(1, 8)) add_token();
    if ($urandom_range(0, 4) == 0 && str_bytes.size() > 1) begin
      cut = $urandom_range(1, str_bytes.size() - 1);
      while (str_bytes.size() > cut) void'(str_bytes.pop_back());
      cut_strings++;
    end
  endtask

  // Receiver: random stall bursts, one long hold on request
  initial begin
    int   low_left;
    logic hold_taken;
    low_left   = 0;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        low_left   = RxHoldCycles;
      end else if (low_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        low_left = $urandom_range(1, 3);
      end
      if (low_left > 0) begin
        m_axis_tready <= 1'b0;
        low_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_json_string_unescape_utf8 failed");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    int directed_beats;
    logic hold_done;
    hold_done = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    quiet         <= 1'b0;
    rx_hold_req   <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extreme plain bytes
    str_bytes = '{8'h00, 8'hFF};
    send_string();
    // every control escape
    str_bytes = '{jsu_pkg::ChBackslash, jsu_pkg::ChLowerB, jsu_pkg::ChBackslash,
                  jsu_pkg::ChLowerF, jsu_pkg::ChBackslash, jsu_pkg::ChLowerN,
                  jsu_pkg::ChBackslash, jsu_pkg::ChLowerR, jsu_pkg::ChBackslash,
                  jsu_pkg::ChLowerT};
    send_string();
    // highest code point through a surrogate pair
    add_hex(16'hDBFF, 1'b0);
    add_hex(16'hDFFF, 1'b0);
    send_string();
    // string that ends right after a backslash
    str_bytes = '{jsu_pkg::ChBackslash};
    send_string();
    directed_beats = beats_sent;

    // sender pauses until the block has emptied
    drain_output();

    while (beats_sent < directed_beats + RandomBeats) begin
      build_random_string();
      if (!hold_done && beats_sent > directed_beats + HoldAfter) begin
        rx_hold_req <= 1'b1;
        hold_done = 1'b1;
      end
      if (beats_sent > directed_beats + QuietAfter) quiet <= 1'b1;
      send_string();
    end

    drain_output();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d beats in %0d strings: %0d \\u escapes, %0d high surrogates, %0d cut short",
             beats_sent, strings_sent, hex_escapes, pair_attempts, cut_strings);
    $display("with random stalls on both sides, a %0d-cycle output hold and a full drain pause",
             RxHoldCycles);
    if (fail_count == 0) begin
      $display("tb_json_string_unescape_utf8 passed");
    end else begin
      $display("tb_json_string_unescape_utf8 failed");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_utf8.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
bench/jsu_unescape_checker.sv
bench/tb_json_string_unescape_utf8.sv
